@@ hdl/usat_pkg.sv @@
// Package: payload types, verdict codes and register indexes of the session table.
package usat_pkg;

   localparam logic [2:0] VERDICT_ACCEPT        = 3'd0;
   localparam logic [2:0] VERDICT_NO_SESSION    = 3'd1;
   localparam logic [2:0] VERDICT_OVERSIZE      = 3'd2;
   localparam logic [2:0] VERDICT_REPLAY        = 3'd3;
   localparam logic [2:0] VERDICT_UNKNOWN_LOCAL = 3'd4;

   localparam logic [1:0] OP_SERVER = 2'd0;
   localparam logic [1:0] OP_LOCAL  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic [1:0] REG_MAX_SESSIONS      = 2'd0;
   localparam logic [1:0] REG_MAX_DATAGRAM_SIZE = 2'd1;
   localparam logic [1:0] REG_IDLE_TIMEOUT_S    = 2'd2;
   localparam logic [1:0] REG_REPLAY_WINDOW     = 2'd3;

   // one stored session row: id, window top, bitmap, tx sequence, activity time
   localparam int ROW_WIDTH = 320;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] sess_key;
      logic [63:0] sequence_req;
      logic [15:0] payload_length;
      logic [63:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [3:0]  slot;
      logic        created;
      logic [63:0] tx_sequence;
      logic [4:0]  expired_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0] sess_key;
      logic [63:0] highest_seen;
      logic [63:0] seen_bitmap;
      logic [63:0] next_tx_seq;
      logic [63:0] last_active_ms;
   } row_type;

endpackage

@@ hdl/usat_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module usat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/udp_session_antireplay_table.sv @@
// Top level: session table with anti-replay windows, sequencer over a row RAM.
//
//   channel | direction | handshake      | payload
//   req_    | in        | valid / stall  | req_type
//   rsp_    | out       | valid / stall  | rsp_type
//   csr_    | in        | valid / ready  | 2-bit index, 64-bit data
//
// Datagram: one id compare a cycle over all rows in SCAN, then read in READ, update
// and write back in UPDATE, result out of DONE; opening a session passes through READ
// twice, and an unknown local session goes from READ straight to DONE.
// Expiry tick: one row read a slot in TICK, then DONE; an unused opcode goes to DONE.
// The row RAM port sets the rate. Active bits are flip-flops, cleared at reset.
// A finished result sits in the output register; requests stall until it leaves.
module udp_session_antireplay_table
   import usat_pkg::*;
#(
   parameter int SESSIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   localparam int AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int CW = $clog2(SESSIONS + 1);
   localparam int NW = (CW > 5) ? CW : 5;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_TICK   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [SESSIONS-1:0] active_ff, active_in;
   logic [AW:0] idx_ff, idx_in;      // scan counter, holds SESSIONS at end
   logic        hit_ff, hit_in;
   logic [AW-1:0] hit_slot_ff, hit_slot_in;
   logic [AW-1:0] chk_slot_ff;      // slot whose row is on rd_data
   logic        chk_ok_ff;
   logic [4:0]  expired_ff, expired_in;
   logic [63:0] limit_ff;

   logic [4:0]  max_sessions_ff;
   logic [15:0] max_dgram_ff;
   logic [15:0] idle_timeout_ff;
   logic [6:0]  replay_window_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   row_type       wr_row, rd_row;
   logic [ROW_WIDTH-1:0] rd_bits;

   usat_ram #(.WIDTH(ROW_WIDTH), .DEPTH(SESSIONS)) u_rows (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_row),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );
   assign rd_row = row_type'(rd_bits);

   // configuration only while idle
   assign csr_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         max_sessions_ff  <= 5'd16;
         max_dgram_ff     <= 16'd1500;
         idle_timeout_ff  <= 16'd60;
         replay_window_ff <= 7'd64;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_SESSIONS:      max_sessions_ff  <= csr_data[4:0];
            REG_MAX_DATAGRAM_SIZE: max_dgram_ff     <= csr_data[15:0];
            REG_IDLE_TIMEOUT_S:    idle_timeout_ff  <= csr_data[15:0];
            REG_REPLAY_WINDOW:     replay_window_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;

   // active count and lowest free slot
   logic [CW-1:0] active_cnt;
   logic          free_any;
   logic [AW-1:0] free_slot;
   always_comb begin
      active_cnt = '0;
      free_any   = 1'b0;
      free_slot  = '0;
      for (int i = 0; i < SESSIONS; i++) begin
         active_cnt = active_cnt + CW'(active_ff[i]);
         if (!active_ff[i] && !free_any) begin
            free_any  = 1'b1;
            free_slot = AW'(i);
         end
      end
   end

   // window check on the row just read
   logic [6:0]  win;
   logic [63:0] seq, hs, jump, behind, bm_new, bit_mask;
   logic        win_ok;
   always_comb begin
      win    = (replay_window_ff > 7'd64) ? 7'd64 : replay_window_ff;
      seq    = req_ff.sequence_req;
      hs     = rd_row.highest_seen;
      jump   = seq - hs;
      behind = hs - seq;
      bit_mask = 64'd1 << behind[5:0];
      bm_new = rd_row.seen_bitmap;
      win_ok = 1'b0;
      if (seq == 64'd0) begin
         win_ok = 1'b0;
      end else if (seq > hs) begin
         win_ok = 1'b1;
         bm_new = (jump >= 64'd64) ? 64'd1 : ((rd_row.seen_bitmap << jump[5:0]) | 64'd1);
      end else if (behind < 64'(win) && !(|(rd_row.seen_bitmap & bit_mask))) begin
         win_ok = 1'b1;
         bm_new = rd_row.seen_bitmap | bit_mask;
      end
   end

   logic [63:0] idle_ms;
   assign idle_ms = req_ff.now_ms - rd_row.last_active_ms;

   logic [AW-1:0] scan_addr;
   assign scan_addr = idx_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      active_in    = active_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      expired_in   = expired_ff;
      wr_en        = 1'b0;
      wr_addr      = hit_slot_ff;
      wr_row       = rd_row;
      rd_addr      = scan_addr;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               idx_in     = '0;
               hit_in     = 1'b0;
               expired_in = '0;
               rsp_in     = '0;
               case (req_data.opcode)
                  OP_SERVER, OP_LOCAL: state_in = ST_SCAN;
                  OP_TICK:             state_in = ST_TICK;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         // one id compare a cycle on the row read the cycle before
         ST_SCAN: begin
            if (chk_ok_ff && active_ff[chk_slot_ff] && !hit_ff
                && rd_row.sess_key == req_ff.sess_key) begin
               hit_in      = 1'b1;
               hit_slot_in = chk_slot_ff;
            end
            if (idx_ff != (AW+1)'(SESSIONS)) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = ST_READ;
            end
         end
         // open a session if needed and allowed, then read the row; else refuse in DONE
         ST_READ: begin
            rd_addr  = hit_slot_ff;
            state_in = ST_UPDATE;
            if (!hit_ff) begin
               if (req_ff.opcode == OP_LOCAL) begin
                  rsp_in.verdict = VERDICT_UNKNOWN_LOCAL;
                  state_in       = ST_DONE;
               end else if (NW'(active_cnt) >= NW'(max_sessions_ff) || !free_any) begin
                  rsp_in.verdict = VERDICT_NO_SESSION;
                  state_in       = ST_DONE;
               end else begin
                  active_in[free_slot] = 1'b1;
                  hit_in         = 1'b1;
                  hit_slot_in    = free_slot;
                  rsp_in.created = 1'b1;
                  wr_en          = 1'b1;
                  wr_addr        = free_slot;
                  wr_row         = '0;
                  wr_row.sess_key       = req_ff.sess_key;
                  wr_row.last_active_ms = req_ff.now_ms;
                  rd_addr        = free_slot;
                  state_in       = ST_READ;
               end
            end
         end
         ST_UPDATE: begin
            rsp_in.slot = 4'(hit_slot_ff);
            wr_row      = rd_row;
            if (req_ff.payload_length > max_dgram_ff) begin
               rsp_in.verdict = VERDICT_OVERSIZE;
            end else if (req_ff.opcode == OP_LOCAL) begin
               wr_en = 1'b1;
               wr_row.next_tx_seq    = rd_row.next_tx_seq + 64'd1;
               wr_row.last_active_ms = req_ff.now_ms;
               rsp_in.tx_sequence    = rd_row.next_tx_seq + 64'd1;
            end else if (!win_ok) begin
               rsp_in.verdict = VERDICT_REPLAY;
            end else begin
               wr_en = 1'b1;
               wr_row.highest_seen   = (seq > hs) ? seq : hs;
               wr_row.seen_bitmap    = bm_new;
               wr_row.last_active_ms = req_ff.now_ms;
            end
            state_in = ST_DONE;
         end
         // one row a cycle; close idle sessions
         ST_TICK: begin
            if (chk_ok_ff && active_ff[chk_slot_ff] && idle_ms > limit_ff) begin
               active_in[chk_slot_ff] = 1'b0;
               if (expired_ff != 5'd31) expired_in = expired_ff + 5'd1;
            end
            if (idx_ff != (AW+1)'(SESSIONS)) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               rsp_in.expired_count = expired_in;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
         chk_ok_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         chk_ok_ff    <= (state_ff == ST_SCAN || state_ff == ST_TICK)
                         && idx_ff < (AW+1)'(SESSIONS) && state_in != ST_IDLE
                         && state_in != ST_READ && state_in != ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      rsp_ff      <= rsp_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      hit_slot_ff <= hit_slot_in;
      expired_ff  <= expired_in;
      chk_slot_ff <= scan_addr;
      // 16-bit seconds times 1000 fits in 26 bits
      limit_ff    <= 64'(26'(idle_timeout_ff) * 26'd1000);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid_ff)
      else $error("result lost");
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> (state_ff == ST_IDLE && !rsp_valid_ff))
      else $error("config while busy");
   a_created_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.created) |-> active_ff[hit_slot_ff])
      else $error("created slot not active");
`endif
endmodule
